### rtl/mexp_pkg.sv
// mexp_pkg: shared types and constants for the modular exponentiation block
// holds the controller state enum and the command and status structs
// no dependencies
package mexp_pkg;

  // modulus value after reset
  localparam logic [30:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_GCD,
    ST_GCD_WAIT,
    ST_SQ_MUL,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MU_MUL,
    ST_MU_GO,
    ST_MU_WAIT,
    ST_OUT
  } mexp_state_t;

  // dividend source of the remainder unit
  typedef enum logic [1:0] {
    SRC_BASE,
    SRC_GCD,
    SRC_PROD
  } rem_src_t;

  typedef struct packed {
    logic     load;
    logic     set_zero;
    logic     rem_go;
    rem_src_t rem_src;
    logic     mul_go;
    logic     mul_sq;
    logic     take_base;
    logic     take_gcd;
    logic     take_r;
    logic     e_shift;
    logic     out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic m_small;
    logic op;
    logic gb_zero;
    logic e_msb;
    logic bits_done;
    logic rem_done;
    logic out_free;
  } mexp_stat_t;

endpackage

### rtl/modular_exponentiation.sv
// modular_exponentiation: top level, base^exponent or Fermat inverse mod a modulus
// depends on mexp_pkg, mexp_ctrl, mexp_dp
//
// usage
//   cfg channel: cfg_valid/cfg_ready write word carries the modulus; ready is
//   always high, write only while the block is idle
//   in channel: in_valid/in_stall word of opcode, base, exponent; one word is
//   worked on at a time and in_stall is high until its result is handed on
//   out channel: out_valid/out_stall word of result and no_inverse, held in an
//   output register, so the next input word can be taken while it waits
// operation
//   each 62-bit reduction runs through a one-bit-per-cycle remainder unit,
//   once per square or multiply step; power: max(EXP_BITS,MOD_BITS) squares
//   plus one multiply per set exponent bit; both opcodes start with a base
//   reduction, and inverse adds the gcd steps
// reset
//   synchronous active-low; modulus returns to 1000000007, block goes idle,
//   output word is dropped
// stall
//   a stalled result stays in the output register; the block then holds its
//   finished value and keeps in_stall high until the register frees
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_modulus,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [30:0] in_base,
  input  logic [31:0] in_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_result,
  output logic        out_no_inverse
);

  mexp_cmd_t  cmd;
  mexp_stat_t st;

  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mexp_dp #(.EXP_BITS(EXP_BITS), .MOD_BITS(MOD_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_modulus    (cfg_modulus),
    .in_opcode      (in_opcode),
    .in_base        (in_base),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result     (out_result),
    .out_no_inverse (out_no_inverse)
  );

endmodule

### rtl/mexp_rem.sv
// mexp_rem: restoring remainder unit, one dividend bit per cycle
// depends on nothing; used by mexp_dp
module mexp_rem #(
  parameter int W  = 31,
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic          done,
  output logic [W-1:0]  rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    diff  = trial - {1'b0, divisor};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/mexp_dp.sv
// mexp_dp: datapath with modulus register, multiplier, remainder unit and output word
// depends on mexp_pkg and mexp_rem
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mexp_cmd_t   cmd,
  output mexp_stat_t  st,
  input  logic        cfg_valid,
  input  logic [30:0] cfg_modulus,
  input  logic        in_opcode,
  input  logic [30:0] in_base,
  input  logic [31:0] in_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_result,
  output logic        out_no_inverse
);

  localparam int W  = MOD_BITS;
  localparam int EW = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;
  localparam int DW = (2 * MOD_BITS > 31) ? 2 * MOD_BITS : 31;
  localparam int CW = $clog2(EW + 1);
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0]   m_r;
  logic           op_r;
  logic [EW-1:0]  e_r;
  logic [CW-1:0]  cnt_r;
  logic [W-1:0]   b_r;
  logic [W-1:0]   r_r;
  logic [W-1:0]   ga_r;
  logic [W-1:0]   gb_r;
  logic [2*W-1:0] prod_r;
  rem_src_t       src_r;
  logic           out_valid_r;
  logic [30:0]    out_result_r;
  logic           out_ni_r;
  logic [63:0]    exp_wide;
  logic [DW-1:0]  rem_dvd;
  logic [W-1:0]   rem_div;
  logic           rem_done;
  logic [W-1:0]   rem_val;
  logic           m_small;

  assign exp_wide = {32'd0, in_exponent};
  assign m_small  = (m_r < W'(2));

  // remainder operand selection
  always_comb begin
    case (cmd.rem_src)
      SRC_BASE: rem_dvd = DW'(in_base);
      SRC_GCD:  rem_dvd = DW'(ga_r);
      SRC_PROD: rem_dvd = DW'(prod_r);
      default:  rem_dvd = '0;
    endcase
    rem_div = (src_r == SRC_GCD) ? gb_r : m_r;
  end

  mexp_rem #(.W(W), .DW(DW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_go),
    .dividend (rem_dvd),
    .divisor  (rem_div),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= MOD_RESET[W-1:0];
    end else if (cfg_valid) begin
      m_r <= cfg_modulus[W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.rem_go) begin
      src_r <= cmd.rem_src;
    end
    if (cmd.load) begin
      op_r  <= in_opcode;
      e_r   <= in_opcode ? EW'(m_r - W'(2)) : EW'(exp_wide[EXP_BITS-1:0]);
      cnt_r <= CW'(EW);
    end else if (cmd.e_shift) begin
      e_r   <= {e_r[EW-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.set_zero) begin
      r_r <= '0;
    end else if (cmd.take_base) begin
      r_r <= ONE;
    end else if (cmd.take_r) begin
      r_r <= rem_val;
    end
    if (cmd.take_base) begin
      b_r  <= rem_val;
      ga_r <= m_r;
      gb_r <= rem_val;
    end else if (cmd.take_gcd) begin
      ga_r <= gb_r;
      gb_r <= rem_val;
    end
    if (cmd.mul_go) begin
      prod_r <= (2*W)'(r_r) * (2*W)'(cmd.mul_sq ? r_r : b_r);
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_result_r <= 31'(r_r);
      out_ni_r     <= op_r & (m_small | (ga_r != ONE));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_no_inverse = out_ni_r;

  // status to controller
  always_comb begin
    st.m_small   = m_small;
    st.op        = op_r;
    st.gb_zero   = (gb_r == '0);
    st.e_msb     = e_r[EW-1];
    st.bits_done = (cnt_r == '0);
    st.rem_done  = rem_done;
    st.out_free  = !out_valid_r || !out_stall;
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while held");

  a_r_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !m_small) |-> (r_r < m_r))
    else $error("result not reduced");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_done && src_r == SRC_PROD) |-> (rem_val < m_r))
    else $error("remainder out of range");

endmodule

### rtl/mexp_ctrl.sv
// mexp_ctrl: sequencer for base reduction, gcd check and square and multiply
// depends on mexp_pkg
module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mexp_stat_t st,
  output mexp_cmd_t  cmd
);

  mexp_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = st.m_small ? ST_OUT : ST_BASE;
      ST_BASE:     if (st.rem_done) state_nxt = st.op ? ST_GCD : ST_SQ_MUL;
      ST_GCD:      state_nxt = st.gb_zero ? ST_SQ_MUL : ST_GCD_WAIT;
      ST_GCD_WAIT: if (st.rem_done) state_nxt = ST_GCD;
      ST_SQ_MUL:   state_nxt = st.bits_done ? ST_OUT : ST_SQ_GO;
      ST_SQ_GO:    state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (st.rem_done) state_nxt = st.e_msb ? ST_MU_MUL : ST_SQ_MUL;
      ST_MU_MUL:   state_nxt = ST_MU_GO;
      ST_MU_GO:    state_nxt = ST_MU_WAIT;
      ST_MU_WAIT:  if (st.rem_done) state_nxt = ST_SQ_MUL;
      ST_OUT:      if (st.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.rem_src = SRC_PROD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.m_small) begin
            cmd.set_zero = 1'b1;
          end else begin
            cmd.rem_go  = 1'b1;
            cmd.rem_src = SRC_BASE;
          end
        end
      end
      ST_BASE:     cmd.take_base = st.rem_done;
      ST_GCD: begin
        if (!st.gb_zero) begin
          cmd.rem_go  = 1'b1;
          cmd.rem_src = SRC_GCD;
        end
      end
      ST_GCD_WAIT: cmd.take_gcd = st.rem_done;
      ST_SQ_MUL: begin
        cmd.mul_go = !st.bits_done;
        cmd.mul_sq = 1'b1;
      end
      ST_SQ_GO:    cmd.rem_go = 1'b1;
      ST_SQ_WAIT: begin
        cmd.take_r  = st.rem_done;
        cmd.e_shift = st.rem_done && !st.e_msb;
      end
      ST_MU_MUL:   cmd.mul_go = 1'b1;
      ST_MU_GO:    cmd.rem_go = 1'b1;
      ST_MU_WAIT: begin
        cmd.take_r  = st.rem_done;
        cmd.e_shift = st.rem_done;
      end
      ST_OUT:      cmd.out_load = st.out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### bench/tb_modular_exponentiation.sv
// tb_modular_exponentiation: self-checking bench for the modular exponentiation block
// drives power and inverse words under random bursts and stalls, predicts every result
// depends on mexp_pkg and modular_exponentiation
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam logic OP_POW = 1'b0;
  localparam logic OP_INV = 1'b1;
  localparam int   IDLE_LIMIT = 40000;

  typedef struct {
    logic        opcode;
    logic [30:0] base;
    logic [31:0] exponent;
  } exp_word_t;

  typedef struct {
    logic [30:0] result;
    logic        no_inverse;
  } res_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_modulus;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [30:0] in_base;
  logic [31:0] in_exponent;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_result;
  logic        out_no_inverse;

  exp_word_t   pending_words[$];
  res_word_t   expected_results[$];
  logic [30:0] cur_modulus;
  int          errors;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;
  int          hold_cycles;
  bit          hold_req;

  modular_exponentiation DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_modulus(cfg_modulus),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_base(in_base), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result(out_result), .out_no_inverse(out_no_inverse)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // multiply mod m with 64-bit product
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a * b) % m;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // expected result of one word under the current modulus
  function automatic res_word_t predict_power(exp_word_t w, logic [30:0] modv);
    res_word_t   r;
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] acc;
    m = {33'd0, modv};
    b = {33'd0, w.base};
    e = {32'd0, w.exponent};
    if (m < 2) begin
      r.result = '0;
      r.no_inverse = w.opcode;
      return r;
    end
    b = b % m;
    r.no_inverse = 1'b0;
    if (w.opcode == OP_INV) begin
      e = m - 2;
      r.no_inverse = (gcd64(b, m) != 1);
    end
    acc = 1;
    for (int i = 63; i >= 0; i--) begin
      acc = mul_mod(acc, acc, m);
      if (e[i]) acc = mul_mod(acc, b, m);
    end
    r.result = acc[30:0] % modv;
    return r;
  endfunction

  function automatic logic [30:0] rand_base();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(0, 20));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_exp();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 8));
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic op, logic [30:0] b, logic [31:0] e);
    exp_word_t w;
    w.opcode = op;
    w.base = b;
    w.exponent = e;
    pending_words.push_back(w);
  endtask

  // write the modulus while idle
  task automatic write_modulus(logic [30:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    cur_modulus = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // driver: bursts and gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_power(pending_words.pop_front(), cur_modulus));
      end
      if (in_valid && in_stall) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        exp_word_t nw;
        nw = pending_words[0];
        in_valid <= 1'b1;
        in_opcode <= nw.opcode;
        in_base <= nw.base;
        in_exponent <= nw.exponent;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 20000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_cycles == 1) begin
      hold_cycles <= -1;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 3) == 0) ? out_stall : 1'b0;
      endcase
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected word result=%0d no_inverse=%0b", $time, out_result,
                 out_no_inverse);
        errors++;
      end else begin
        res_word_t x;
        x = expected_results.pop_front();
        if (x.result !== out_result) begin
          $display("%0t result mismatch expected %0d actual %0d", $time, x.result, out_result);
          errors++;
        end
        if (x.no_inverse !== out_no_inverse) begin
          $display("%0t no_inverse mismatch expected %0b actual %0b", $time, x.no_inverse,
                   out_no_inverse);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n
        || hold_cycles > 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [30:0] moduli[6];
    errors = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_modulus = '0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_base = '0;
    in_exponent = '0;
    out_stall = 1'b0;
    cur_modulus = MOD_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset modulus
    push_word(OP_POW, 31'd0, 32'd0);
    push_word(OP_POW, 31'd5, 32'd0);
    push_word(OP_POW, 31'h7fffffff, 32'hffffffff);
    push_word(OP_POW, 31'd0, 32'd7);
    push_word(OP_POW, 31'd2, 32'd10);
    push_word(OP_POW, 31'd1000000007, 32'd3);
    push_word(OP_INV, 31'd0, 32'd0);
    push_word(OP_INV, 31'd3, 32'hffffffff);
    push_word(OP_INV, 31'h7fffffff, 32'd0);
    push_word(OP_INV, 31'd2000000014, 32'd5);
    drain();

    // composite modulus exercises the missing-inverse flag
    write_modulus(31'd12);
    push_word(OP_INV, 31'd4, 32'd0);
    push_word(OP_INV, 31'd5, 32'd0);
    push_word(OP_POW, 31'd7, 32'd2);
    drain();

    // modulus below two
    write_modulus(31'd1);
    push_word(OP_POW, 31'd9, 32'd3);
    push_word(OP_INV, 31'd9, 32'd3);
    drain();
    write_modulus(31'd0);
    push_word(OP_INV, 31'd0, 32'd0);
    push_word(OP_POW, 31'h7fffffff, 32'hffffffff);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_modulus(31'h7fffffff);
    for (int i = 0; i < 6; i++) push_word(1'($urandom), rand_base(), rand_exp());
    hold_req = 1'b1;
    wait (hold_cycles > 0);
    hold_req = 1'b0;
    drain();

    // random phases over several moduli
    moduli[0] = 31'd2;
    moduli[1] = 31'h7fffffff;
    moduli[2] = 31'd97;
    moduli[3] = 31'd1000000007;
    moduli[4] = 31'd65536;
    moduli[5] = 31'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_modulus(moduli[p]);
      for (int i = 0; i < 20; i++) push_word(1'($urandom), rand_base(), rand_exp());
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
